FILE: sv/tlps_pkg.sv
`timescale 1ns / 1ps

package tlps_pkg;

  localparam int SlotsDefault = 64;
  localparam int MaskW        = 64;
  localparam int IdxOutW      = 6;
  localparam int CntW         = 8;
  localparam int LvlW         = 2;
  localparam int CfgW         = 8;
  localparam int CfgIdxW      = 1;

  localparam logic [LvlW-1:0] LvlLow  = 2'd0;
  localparam logic [LvlW-1:0] LvlMed  = 2'd1;
  localparam logic [LvlW-1:0] LvlHigh = 2'd2;

  localparam logic [CfgIdxW-1:0] RegPromote = 1'd0;
  localparam logic [CfgIdxW-1:0] RegDemote  = 1'd1;

  localparam logic [CntW-1:0] PromoteRst = 8'd10;
  localparam logic [CntW-1:0] DemoteRst  = 8'd4;
  localparam logic [CntW-1:0] CntMax     = 8'd255;

  typedef struct packed {
    logic load;
    logic grab;
    logic advance;
    logic apply;
    logic emit_idle;
  } tlps_cmd_t;

  typedef struct packed {
    logic hit;
    logic idle_done;
  } tlps_stat_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == CntMax) ? CntMax : v + CntW'(1);
  endfunction

endpackage

FILE: sv/tlps_ram.sv
`timescale 1ns / 1ps

module tlps_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/tlps_ctrl.sv
`timescale 1ns / 1ps

module tlps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  tlps_pkg::tlps_stat_t stat_i,
  output tlps_pkg::tlps_cmd_t  cmd_o,
  output logic                busy
);

  import tlps_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StRead,
    StApply
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = StScan;
        end
      end
      StScan: begin
        if (stat_i.hit) begin
          cmd_o.grab = 1'b1;
          state_d    = StRead;
        end else begin
          cmd_o.advance = 1'b1;
          if (stat_i.idle_done) begin
            cmd_o.emit_idle = 1'b1;
            state_d         = StIdle;
          end
        end
      end
      StRead: begin
        state_d = StApply;
      end
      StApply: begin
        cmd_o.apply = 1'b1;
        state_d     = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != StIdle);
    end
  end

  assign busy = busy_q;

endmodule

FILE: sv/tlps_dp.sv
`timescale 1ns / 1ps

module tlps_dp #(
  parameter int Slots = tlps_pkg::SlotsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tlps_pkg::tlps_cmd_t          cmd_i,
  output tlps_pkg::tlps_stat_t         stat_o,
  input  logic [tlps_pkg::MaskW-1:0]   runnable_mask_i,
  input  logic                         cfg_we_i,
  input  logic [tlps_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tlps_pkg::CfgW-1:0]    cfg_wdata_i,
  output logic                         done_o,
  output logic                         granted_o,
  output logic [tlps_pkg::IdxOutW-1:0] grant_index_o,
  output logic [tlps_pkg::LvlW-1:0]    grant_level_o
);

  import tlps_pkg::*;

  localparam int IdxW = $clog2(Slots);

  logic [CntW-1:0]  promote_q, promote_d;
  logic [CntW-1:0]  demote_q, demote_d;
  logic [LvlW-1:0]  prio_q [Slots];
  logic [LvlW-1:0]  prio_d [Slots];
  logic [Slots-1:0] valid_q, valid_d;
  logic [CntW-1:0]  mrc_q, mrc_d;
  logic [CntW-1:0]  lrc_q, lrc_d;
  logic [LvlW-1:0]  pass_q, pass_d;
  logic [IdxW-1:0]  pos_q, pos_d;
  logic             fh_q, fh_d;
  logic             fm_q, fm_d;
  logic             fresh_q, fresh_d;
  logic [Slots-1:0] mask_q, mask_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             res_valid_q, res_valid_d;
  logic             res_granted_q, res_granted_d;
  logic [IdxW-1:0]  res_index_q, res_index_d;
  logic [LvlW-1:0]  res_level_q, res_level_d;

  logic [Slots-1:0] hit_vec;
  logic [IdxW-1:0]  hit_idx;
  logic             hit_any;
  logic             pass_done;
  logic             ram_we;
  logic [CntW-1:0]  ram_wdata;
  logic [CntW-1:0]  ram_rdata;
  logic [CntW-1:0]  run_cur;

  tlps_ram #(
    .Width (CntW),
    .Depth (Slots)
  ) u_run_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign run_cur = valid_q[idx_q] ? ram_rdata : '0;

  // priority encoder, lowest runnable slot of the current level at or after the scan position
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < Slots; i++) begin
      hit_vec[i] = mask_q[i] && (prio_q[i] == pass_q) && (IdxW'(i) >= pos_q);
    end
    for (int i = Slots - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IdxW'(i);
      end
    end
  end

  assign hit_any = |hit_vec;

  always_comb begin
    case (pass_q)
      LvlHigh: pass_done = fh_q;
      LvlMed:  pass_done = fm_q;
      default: pass_done = 1'b1;
    endcase
  end

  assign stat_o.hit       = hit_any;
  assign stat_o.idle_done = !hit_any && pass_done && fresh_q;

  always_comb begin
    logic do_round_end;
    do_round_end  = 1'b0;
    promote_d     = promote_q;
    demote_d      = demote_q;
    prio_d        = prio_q;
    valid_d       = valid_q;
    mrc_d         = mrc_q;
    lrc_d         = lrc_q;
    pass_d        = pass_q;
    pos_d         = pos_q;
    fh_d          = fh_q;
    fm_d          = fm_q;
    fresh_d       = fresh_q;
    mask_d        = mask_q;
    idx_d         = idx_q;
    res_valid_d   = 1'b0;
    res_granted_d = res_granted_q;
    res_index_d   = res_index_q;
    res_level_d   = res_level_q;
    ram_we        = 1'b0;
    ram_wdata     = sat_inc(run_cur);

    if (cmd_i.load) begin
      mask_d  = runnable_mask_i[Slots-1:0];
      fresh_d = (pass_q == LvlHigh) && (pos_q == '0) && !fh_q && !fm_q;
    end

    if (cmd_i.grab) begin
      idx_d = hit_idx;
    end

    if (cmd_i.advance) begin
      if (!pass_done) begin
        pass_d = (pass_q == LvlHigh) ? LvlMed : LvlLow;
        pos_d  = '0;
      end else begin
        do_round_end = 1'b1;
        fresh_d      = 1'b1;
      end
    end

    if (cmd_i.apply) begin
      case (pass_q)
        LvlHigh: begin
          prio_d[idx_q] = LvlMed;
          fh_d          = 1'b1;
        end
        LvlMed: begin
          if (mrc_q == promote_q) begin
            prio_d[idx_q] = LvlHigh;
            mrc_d         = '0;
          end
          // demotion wins over promotion
          if (run_cur == demote_q) begin
            prio_d[idx_q] = LvlLow;
          end
          ram_we         = 1'b1;
          valid_d[idx_q] = 1'b1;
          fm_d           = 1'b1;
        end
        LvlLow: begin
          if (lrc_q == promote_q) begin
            prio_d[idx_q] = LvlHigh;
            lrc_d         = '0;
          end
          valid_d[idx_q] = 1'b0;
        end
        default: begin
        end
      endcase
      // a grant on the last slot always closes the round
      if (idx_q == IdxW'(Slots - 1)) begin
        do_round_end = 1'b1;
      end else begin
        pos_d = idx_q + IdxW'(1);
      end
      res_valid_d   = 1'b1;
      res_granted_d = 1'b1;
      res_index_d   = idx_q;
      res_level_d   = pass_q;
    end

    if (do_round_end) begin
      mrc_d  = sat_inc(mrc_d);
      lrc_d  = sat_inc(lrc_d);
      pass_d = LvlHigh;
      pos_d  = '0;
      fh_d   = 1'b0;
      fm_d   = 1'b0;
    end

    if (cmd_i.emit_idle) begin
      res_valid_d   = 1'b1;
      res_granted_d = 1'b0;
      res_index_d   = '0;
      res_level_d   = LvlLow;
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPromote: promote_d = cfg_wdata_i;
        RegDemote:  demote_d  = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      promote_q   <= PromoteRst;
      demote_q    <= DemoteRst;
      for (int i = 0; i < Slots; i++) begin
        prio_q[i] <= LvlLow;
      end
      valid_q     <= '0;
      mrc_q       <= '0;
      lrc_q       <= '0;
      pass_q      <= LvlHigh;
      pos_q       <= '0;
      fh_q        <= 1'b0;
      fm_q        <= 1'b0;
      fresh_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      promote_q   <= promote_d;
      demote_q    <= demote_d;
      prio_q      <= prio_d;
      valid_q     <= valid_d;
      mrc_q       <= mrc_d;
      lrc_q       <= lrc_d;
      pass_q      <= pass_d;
      pos_q       <= pos_d;
      fh_q        <= fh_d;
      fm_q        <= fm_d;
      fresh_q     <= fresh_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q        <= mask_d;
    idx_q         <= idx_d;
    res_granted_q <= res_granted_d;
    res_index_q   <= res_index_d;
    res_level_q   <= res_level_d;
  end

  assign done_o        = res_valid_q;
  assign granted_o     = res_granted_q;
  assign grant_index_o = IdxOutW'(res_index_q);
  assign grant_level_o = res_level_q;

  a_grab_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.grab |-> hit_any)
    else $error("grab without a runnable match");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_granted_q) |-> (res_index_q == '0 && res_level_q == LvlLow))
    else $error("idle result carries a nonzero index or level");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |=> !res_valid_q)
    else $error("result strobe held for two cycles");

  a_pass_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply |-> (pass_q == LvlHigh || pass_q == LvlMed || pass_q == LvlLow))
    else $error("grant applied in the unused pass");

endmodule

FILE: sv/three_level_priority_scheduler.sv
`timescale 1ns / 1ps

// Three-level feedback scheduler with a resumable scan. Assert start while
// busy is low to issue a request with a runnable mask; exactly one result
// follows, shown for a single cycle with done_o high, and it must be taken
// then because the receiver cannot hold it off. Each scan cycle runs one
// priority-encoder pass over the slots of the current level at or after the
// scan position; the scan may move down the levels and wrap the round
// before it finds a grant or gives an idle result. A grant then passes
// through a read and an apply state, as the per-slot run count is read and
// written through one memory with a registered read. The result appears
// in the cycle in which busy falls, and a new request may start in that
// same cycle. Write promote_after (index 0) and demote_after (index 1)
// only while the block is idle.
module three_level_priority_scheduler #(
  parameter int Slots = tlps_pkg::SlotsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [tlps_pkg::MaskW-1:0]   runnable_mask_i,
  input  logic                         cfg_we_i,
  input  logic [tlps_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tlps_pkg::CfgW-1:0]    cfg_wdata_i,
  output logic                         done_o,
  output logic                         granted_o,
  output logic [tlps_pkg::IdxOutW-1:0] grant_index_o,
  output logic [tlps_pkg::LvlW-1:0]    grant_level_o
);

  import tlps_pkg::*;

  tlps_cmd_t  cmd;
  tlps_stat_t stat;

  tlps_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  tlps_dp #(
    .Slots (Slots)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .runnable_mask_i (runnable_mask_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .granted_o       (granted_o),
    .grant_index_o   (grant_index_o),
    .grant_level_o   (grant_level_o)
  );

endmodule

FILE: bench/grant_checker.sv
`timescale 1ns / 1ps

module grant_checker
  import tlps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [MaskW-1:0]   mask_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               done_i,
  input  logic               granted_i,
  input  logic [IdxOutW-1:0] index_i,
  input  logic [LvlW-1:0]    level_i,
  output int                 errors_o,
  output int                 pending_o
);

  localparam int NumSlots = SlotsDefault;

  typedef struct packed {
    logic               granted;
    logic [IdxOutW-1:0] index;
    logic [LvlW-1:0]    level;
  } grant_t;

  grant_t grants_due[$];

  logic [CntW-1:0] promote_thr;
  logic [CntW-1:0] demote_thr;
  logic [LvlW-1:0] lvl_q [NumSlots];
  logic [CntW-1:0] runs_q [NumSlots];
  logic [CntW-1:0] med_rounds;
  logic [CntW-1:0] low_rounds;
  logic [LvlW-1:0] pass_q;
  logic [5:0]      pos_q;
  logic            hit_hi;
  logic            hit_med;

  function automatic logic [CntW-1:0] sat_bump(input logic [CntW-1:0] v);
    return (v == {CntW{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic void wrap_round();
    med_rounds = sat_bump(med_rounds);
    low_rounds = sat_bump(low_rounds);
    pass_q = LvlHigh;
    pos_q = '0;
    hit_hi = 1'b0;
    hit_med = 1'b0;
  endfunction

  // returns 1 when the round wrapped
  function automatic logic close_pass();
    if (pass_q == LvlHigh && !hit_hi) begin
      pass_q = LvlMed;
      pos_q = '0;
      return 1'b0;
    end
    if (pass_q == LvlMed && !hit_med) begin
      pass_q = LvlLow;
      pos_q = '0;
      return 1'b0;
    end
    wrap_round();
    return 1'b1;
  endfunction

  function automatic grant_t next_grant(input logic [MaskW-1:0] mask);
    grant_t r;
    logic fresh;
    logic stop;
    logic wrapped;
    int i;
    int g;
    r = '0;
    fresh = (pass_q == LvlHigh) && (pos_q == '0) && !hit_hi && !hit_med;
    stop = 1'b0;
    for (g = 0; g < 8 && !stop; g++) begin
      if (pass_q <= LvlHigh) begin
        for (i = int'(pos_q); i < NumSlots && !stop; i++) begin
          if (mask[i] && lvl_q[i] == pass_q) begin
            r.granted = 1'b1;
            r.index = IdxOutW'(i);
            r.level = pass_q;
            case (pass_q)
              LvlHigh: begin
                lvl_q[i] = LvlMed;
                hit_hi = 1'b1;
              end
              LvlMed: begin
                if (med_rounds == promote_thr) begin
                  lvl_q[i] = LvlHigh;
                  med_rounds = '0;
                end
                if (runs_q[i] == demote_thr) lvl_q[i] = LvlLow;
                runs_q[i] = sat_bump(runs_q[i]);
                hit_med = 1'b1;
              end
              default: begin
                if (low_rounds == promote_thr) begin
                  lvl_q[i] = LvlHigh;
                  low_rounds = '0;
                end
                runs_q[i] = '0;
              end
            endcase
            if (i + 1 >= NumSlots) wrapped = close_pass();
            else pos_q = 6'(i + 1);
            stop = 1'b1;
          end
        end
      end
      if (!stop) begin
        if (pass_q > LvlHigh) begin
          wrap_round();
          wrapped = 1'b1;
        end else begin
          wrapped = close_pass();
        end
        if (wrapped) begin
          if (fresh) stop = 1'b1;
          else fresh = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t grant_checker: %s", $realtime, what);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t exp_r;
    if (!rst_ni) begin
      promote_thr = PromoteRst;
      demote_thr = DemoteRst;
      for (int s = 0; s < NumSlots; s++) begin
        lvl_q[s] = LvlLow;
        runs_q[s] = '0;
      end
      med_rounds = '0;
      low_rounds = '0;
      pass_q = LvlHigh;
      pos_q = '0;
      hit_hi = 1'b0;
      hit_med = 1'b0;
      grants_due.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegPromote: promote_thr = cfg_wdata_i;
          RegDemote:  demote_thr = cfg_wdata_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) grants_due.push_back(next_grant(mask_i));
      if (done_i) begin
        if (grants_due.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          exp_r = grants_due.pop_front();
          if (granted_i !== exp_r.granted)
            report_mismatch($sformatf("granted %0b, want %0b", granted_i, exp_r.granted));
          if (index_i !== exp_r.index)
            report_mismatch($sformatf("grant_index %0d, want %0d", index_i, exp_r.index));
          if (level_i !== exp_r.level)
            report_mismatch($sformatf("grant_level %0d, want %0d", level_i, exp_r.level));
        end
      end
      pending_o = grants_due.size();
    end
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tlps_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [MaskW-1:0]   runnable_mask;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_wdata;
  logic               done;
  logic               granted;
  logic [IdxOutW-1:0] grant_index;
  logic [LvlW-1:0]    grant_level;
  int                 errors;
  int                 pending;

  three_level_priority_scheduler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .runnable_mask_i(runnable_mask),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .done_o         (done),
    .granted_o      (granted),
    .grant_index_o  (grant_index),
    .grant_level_o  (grant_level)
  );

  grant_checker u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_i     (busy),
    .mask_i     (runnable_mask),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .done_i     (done),
    .granted_i  (granted),
    .index_i    (grant_index),
    .level_i    (grant_level),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send(input logic [MaskW-1:0] m);
    start <= 1'b1;
    runnable_mask <= m;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic settle();
    start <= 1'b0;
    runnable_mask <= {$urandom, $urandom};
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [MaskW-1:0] m;
    logic [CfgW-1:0]  prom [6];
    logic [CfgW-1:0]  dem [6];
    int               sent;
    int               burst;
    int               ph;
    int               k;

    rst_ni = 1'b0;
    start = 1'b0;
    runnable_mask = '0;
    cfg_we = 1'b0;
    cfg_idx = RegPromote;
    cfg_wdata = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset thresholds: idle round, low grants, last slot
    send('0);
    send({MaskW{1'b1}});
    send(64'd1 << 63);
    send(64'd1);
    send('0);
    settle();

    // immediate promotion and demotion to reach every level
    write_reg(RegPromote, 8'd0);
    write_reg(RegDemote, 8'd1);
    repeat (6) send({MaskW{1'b1}});
    repeat (3) send(64'd1 << 63);
    send(64'h8000_0000_0000_0001);
    send(64'hAAAA_AAAA_AAAA_AAAA);
    send(64'h5555_5555_5555_5555);
    send('0);
    send('0);
    send({MaskW{1'b1}});
    send(64'd1);

    prom = '{8'd10, 8'd0, 8'd255, 8'd1, 8'd3, 8'($urandom)};
    dem  = '{8'd4, 8'd0, 8'd255, 8'd0, 8'd1, 8'($urandom)};
    for (ph = 0; ph < 6; ph++) begin
      settle();
      write_reg(RegPromote, prom[ph]);
      write_reg(RegDemote, dem[ph]);
      sent = 0;
      while (sent < 315) begin
        burst = $urandom_range(1, 24);
        for (k = 0; k < burst; k++) begin
          case ($urandom_range(0, 9))
            0: m = '0;
            1: m = {MaskW{1'b1}};
            2: m = 64'd1 << $urandom_range(0, 63);
            3: m = (64'd1 << 63) | (64'd1 << $urandom_range(0, 62));
            4, 5: m = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            default: m = {$urandom, $urandom};
          endcase
          send(m);
          sent++;
        end
        if ($urandom_range(0, 3) != 0) begin
          start <= 1'b0;
          runnable_mask <= {$urandom, $urandom};
          repeat ($urandom_range(1, 8)) @(negedge clk_i);
        end
      end
    end

    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/tlps_pkg.sv
sv/tlps_ram.sv
sv/tlps_ctrl.sv
sv/tlps_dp.sv
sv/three_level_priority_scheduler.sv
bench/grant_checker.sv
bench/tb_top.sv
